### sv/byte_run_image_decoder_unit_defines.svh
// ---------------------------------------------------------------------------
// Byte-run image decoder assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BYTE_RUN_IMAGE_DECODER_UNIT_DEFINES_SVH
`define BYTE_RUN_IMAGE_DECODER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// condition must hold at every edge
`define BRID_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("brid assertion failed");
// consequent must hold in the cycle after the antecedent
`define BRID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brid assertion failed");
`else
`define BRID_ASSERT(lbl, cond)
`define BRID_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/brid_pkg.sv
// ---------------------------------------------------------------------------
// brid_pkg
// Types, constants and helpers for the byte-run image decoder.
// ---------------------------------------------------------------------------
package brid_pkg;

    // dimension limits
    localparam int MAX_DIMENSION = 2048;
    localparam int DIM_W         = 12;
    localparam int ROW_W         = 11;
    localparam int COL_W         = 11;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_STRIDE   = 2'd2;

    // register reset values
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 12'd320;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 12'd200;
    localparam logic [DIM_W-1:0] RST_ROW_STRIDE   = 12'd320;

    // value of a pad pixel
    localparam logic [7:0] PAD_PIXEL = 8'hFF;

    // output queue depth
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // parser phase
    typedef enum logic [3:0] {
        PH_ROWCOUNT = 4'b0001,
        PH_COUNT    = 4'b0010,
        PH_VALUE    = 4'b0100,
        PH_LITERAL  = 4'b1000
    } brid_phase_t;

    // input item
    typedef struct packed {
        logic       chunk_start;
        logic [7:0] data_byte;
    } brid_in_t;

    // result item: one run record
    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [COL_W-1:0] column_index;
        logic [7:0]       pixel_value;
        logic [DIM_W-1:0] run_length;
        logic             is_padding;
        logic             frame_done;
        logic             last_result;
    } brid_out_t;

    // zero reads as one, anything above the limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIMENSION))
            r = DIM_W'(MAX_DIMENSION);
        else
            r = v;
        return r;
    endfunction

endpackage

### sv/byte_run_image_decoder_unit.sv
// ---------------------------------------------------------------------------
// byte_run_image_decoder_unit
// Takes one byte of a byte-run image chunk body per cycle and turns it into
// run records (row, column, pixel, length), including 0xFF pad runs from the
// width out to the stride. A byte is accepted every cycle while the output
// is drained every cycle; a result passes through the input register, then
// the output queue. A byte that ends a row can yield two records (its own
// run and the pad run); the 4-entry output queue absorbs these, and input
// stalls only when more than two records are waiting. Bytes after the last
// row give no records until chunk_start.
// ---------------------------------------------------------------------------
`include "byte_run_image_decoder_unit_defines.svh"

module byte_run_image_decoder_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [brid_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [brid_pkg::DIM_W-1:0]            cfg_data,
    // encoded bytes in
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  brid_pkg::brid_in_t                    in_item,
    // run records out
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output brid_pkg::brid_out_t                   out_item
);
    import brid_pkg::*;

    // configuration registers
    logic [DIM_W-1:0] width_cfg_reg;
    logic [DIM_W-1:0] height_cfg_reg;
    logic [DIM_W-1:0] stride_cfg_reg;

    // input register
    logic     s1_valid_reg;
    brid_in_t s1_reg;

    // parse state
    brid_phase_t      phase_reg, phase_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [7:0]       lit_reg, lit_next;
    logic [7:0]       rep_reg, rep_next;
    logic             done_reg, done_next;

    // output queue
    brid_out_t           oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg;
    logic [OQ_PTR_W-1:0] rd_ptr_reg;
    logic [OQ_CNT_W-1:0] cnt_reg;

    // datapath
    logic [DIM_W-1:0] width_eff, height_eff, stride_eff, stride_clamp;
    logic             proc;
    logic             pop;
    brid_phase_t      ph_eff;
    logic [ROW_W-1:0] row_eff;
    logic [DIM_W-1:0] col_eff;
    logic [7:0]       lit_eff;
    logic [7:0]       rep_eff;
    logic             done_eff;
    logic [DIM_W-1:0] room;
    logic [DIM_W-1:0] run_len;
    logic [DIM_W-1:0] col_a;
    logic             pkt_end;
    logic             frame;
    logic             res0_v, res1_v;
    brid_out_t        res0, res1;
    brid_out_t        push_a, push_b;
    logic [1:0]       push_n;

    assign cfg_ready = 1'b1;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= RST_IMAGE_WIDTH;
            height_cfg_reg <= RST_IMAGE_HEIGHT;
            stride_cfg_reg <= RST_ROW_STRIDE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                CFG_ROW_STRIDE:   stride_cfg_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // effective dimensions; stride never below width
    always_comb
    begin
        width_eff    = clamp_dim(width_cfg_reg);
        height_eff   = clamp_dim(height_cfg_reg);
        stride_clamp = clamp_dim(stride_cfg_reg);
        stride_eff   = (stride_clamp < width_eff) ? width_eff : stride_clamp;
    end

    // handshakes: the held byte is processed when the queue has room for two
    assign pop      = out_valid && out_ready;
    assign proc     = s1_valid_reg && (cnt_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign in_ready = !s1_valid_reg || proc;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_reg <= in_item;
    end

    // parse one byte
    always_comb
    begin
        // chunk_start restarts row state before the byte is parsed
        ph_eff   = s1_reg.chunk_start ? PH_ROWCOUNT : phase_reg;
        row_eff  = s1_reg.chunk_start ? '0 : row_reg;
        col_eff  = s1_reg.chunk_start ? '0 : col_reg;
        lit_eff  = s1_reg.chunk_start ? '0 : lit_reg;
        rep_eff  = s1_reg.chunk_start ? '0 : rep_reg;
        done_eff = s1_reg.chunk_start ? 1'b0 : done_reg;

        phase_next = ph_eff;
        row_next   = row_eff;
        col_next   = col_eff;
        lit_next   = lit_eff;
        rep_next   = rep_eff;
        done_next  = done_eff;

        room    = stride_eff - col_eff;
        run_len = (DIM_W'(rep_eff) > room) ? room : DIM_W'(rep_eff);
        col_a   = col_eff;
        pkt_end = 1'b0;
        frame   = 1'b0;
        res0_v  = 1'b0;
        res1_v  = 1'b0;

        res0.row_index    = row_eff;
        res0.column_index = col_eff[COL_W-1:0];
        res0.pixel_value  = s1_reg.data_byte;
        res0.run_length   = DIM_W'(1);
        res0.is_padding   = 1'b0;
        res0.frame_done   = 1'b0;
        res0.last_result  = 1'b0;

        if (!done_eff)
        begin
            unique case (ph_eff)
                PH_ROWCOUNT:
                begin
                    phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    if (!s1_reg.data_byte[7])
                    begin
                        rep_next   = s1_reg.data_byte;
                        phase_next = PH_VALUE;
                    end
                    else
                    begin
                        // 256 - count, 0x80 gives 128
                        lit_next   = ~s1_reg.data_byte + 8'd1;
                        phase_next = PH_LITERAL;
                    end
                end
                PH_VALUE:
                begin
                    if (rep_eff != '0 && col_eff < stride_eff)
                    begin
                        res0_v          = 1'b1;
                        res0.run_length = run_len;
                        col_a           = col_eff + run_len;
                    end
                    rep_next = '0;
                    pkt_end  = 1'b1;
                end
                PH_LITERAL:
                begin
                    // literals past the stride are consumed silently
                    if (col_eff < stride_eff)
                    begin
                        res0_v = 1'b1;
                        col_a  = col_eff + DIM_W'(1);
                    end
                    if (lit_eff <= 8'd1)
                    begin
                        lit_next = '0;
                        pkt_end  = 1'b1;
                    end
                    else
                    begin
                        lit_next = lit_eff - 8'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_ROWCOUNT;
                end
            endcase
            col_next = col_a;
        end

        // pad run from the column out to the stride
        res1.row_index    = row_eff;
        res1.column_index = col_a[COL_W-1:0];
        res1.pixel_value  = PAD_PIXEL;
        res1.run_length   = stride_eff - col_a;
        res1.is_padding   = 1'b1;
        res1.frame_done   = 1'b0;
        res1.last_result  = 1'b0;

        // end of packet: close the row once the width is reached
        if (pkt_end)
        begin
            if (col_a >= width_eff)
            begin
                res1_v = (col_a < stride_eff);
                if ((DIM_W'(row_eff) + DIM_W'(1)) >= height_eff)
                begin
                    done_next = 1'b1;
                    frame     = 1'b1;
                end
                else
                begin
                    row_next = row_eff + ROW_W'(1);
                end
                col_next   = '0;
                phase_next = PH_ROWCOUNT;
            end
            else
            begin
                phase_next = PH_COUNT;
            end
        end

        // mark the last record of this byte
        if (res1_v)
        begin
            res1.last_result = 1'b1;
            res1.frame_done  = frame;
        end
        else
        begin
            res0.last_result = 1'b1;
            res0.frame_done  = frame;
        end

        // pack records for the queue
        if (res0_v)
        begin
            push_a = res0;
            push_b = res1;
            push_n = res1_v ? 2'd2 : 2'd1;
        end
        else
        begin
            push_a = res1;
            push_b = res1;
            push_n = res1_v ? 2'd1 : 2'd0;
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ROWCOUNT;
            row_reg   <= '0;
            col_reg   <= '0;
            lit_reg   <= '0;
            rep_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            lit_reg   <= lit_next;
            rep_reg   <= rep_next;
            done_reg  <= done_next;
        end
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (proc && push_n != 2'd0)
            oq_mem[wr_ptr_reg] <= push_a;
        if (proc && push_n == 2'd2)
            oq_mem[wr_ptr_reg + OQ_PTR_W'(1)] <= push_b;
    end

    // output queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (proc)
                wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            cnt_reg <= cnt_reg + (proc ? OQ_CNT_W'(push_n) : '0) - OQ_CNT_W'(pop);
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_item  = oq_mem[rd_ptr_reg];

    // checks
    `BRID_ASSERT(a_oq_bound, cnt_reg <= OQ_CNT_W'(OQ_DEPTH))
    `BRID_ASSERT(a_run_nonzero, !out_valid || out_item.run_length != '0)
    `BRID_ASSERT(a_pad_value, !out_valid || !out_item.is_padding || out_item.pixel_value == PAD_PIXEL)
    `BRID_ASSERT(a_idle_silent, !(proc && done_reg && !s1_reg.chunk_start) || push_n == 2'd0)
    `BRID_ASSERT_NEXT(a_frame_sets_done, proc && frame, done_reg && phase_reg == PH_ROWCOUNT)

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-run image decoder testbench
// Streams encoded chunk bodies into byte_run_image_decoder_unit through a
// bursty driver, predicts every run record from its own copy of the parser
// state and registers, and checks each record at a stalling monitor. Register
// settings change between phases, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    import brid_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD        = 80;
    localparam int RUN_LIMIT_CYCLES = 250000;
    localparam int PHASE_BYTES      = 18;
    localparam int WIDE_BYTES       = 45;
    localparam int NUM_PHASES       = 14;
    localparam int MAX_PRINTED      = 50;

    typedef struct packed {
        logic [CFG_ADDR_W-1:0] addr;
        logic [DIM_W-1:0]      data;
    } reg_write_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [DIM_W-1:0]      cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    brid_in_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    brid_out_t             out_item;

    byte_run_image_decoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // pending bytes, pending register writes, expected run records
    brid_in_t   byte_q[$];
    reg_write_t reg_write_q[$];
    brid_out_t  run_q[$];
    int         error_count = 0;

    // register copy, raw as written
    logic [DIM_W-1:0] reg_width  = RST_IMAGE_WIDTH;
    logic [DIM_W-1:0] reg_height = RST_IMAGE_HEIGHT;
    logic [DIM_W-1:0] reg_stride = RST_ROW_STRIDE;

    // parser state copy
    brid_phase_t      parse_state   = PH_ROWCOUNT;
    logic [ROW_W-1:0] row_now       = '0;
    logic [DIM_W-1:0] col_now       = '0;
    logic [7:0]       literals_left = '0;
    logic [7:0]       repeat_len    = '0;
    logic             frame_over    = 1'b0;

    // stream generator state (effective dimensions)
    int gen_w;
    int gen_h;
    int gen_s;
    int rows_left         = 0;
    int bytes_made        = 0;
    bit long_literal_due  = 1'b0;

    // sender bursts
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall pattern and long hold-off
    int         cycle_count   = 0;
    int         stall_mode    = 0;
    logic [7:0] stall_mask    = 8'hFF;
    int         hold_left     = 0;
    int         hold_requests = 0;
    int         holds_taken   = 0;

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // zero reads as one, above the limit reads as the limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        if (v > DIM_W'(MAX_DIMENSION))
            return DIM_W'(MAX_DIMENSION);
        return v;
    endfunction

    function automatic brid_out_t make_run(input logic [DIM_W-1:0] col,
                                           input logic [7:0] val,
                                           input logic [DIM_W-1:0] len,
                                           input logic pad);
        brid_out_t r;
        r              = '0;
        r.row_index    = row_now;
        r.column_index = col[COL_W-1:0];
        r.pixel_value  = val;
        r.run_length   = len;
        r.is_padding   = pad;
        return r;
    endfunction

    // advance the parser copy by one byte and queue the runs it yields
    function automatic void decode_byte(input brid_in_t it);
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] s;
        logic [DIM_W-1:0] len;
        logic             pkt_end;
        logic             frame;
        brid_out_t        runs[$];
        w = eff_dim(reg_width);
        h = eff_dim(reg_height);
        s = eff_dim(reg_stride);
        if (s < w)
            s = w;
        pkt_end = 1'b0;
        frame   = 1'b0;
        if (it.chunk_start)
        begin
            parse_state   = PH_ROWCOUNT;
            row_now       = '0;
            col_now       = '0;
            literals_left = '0;
            repeat_len    = '0;
            frame_over    = 1'b0;
        end
        if (!frame_over)
        begin
            case (parse_state)
                PH_ROWCOUNT:
                    parse_state = PH_COUNT;
                PH_COUNT:
                begin
                    if (!it.data_byte[7])
                    begin
                        repeat_len  = it.data_byte;
                        parse_state = PH_VALUE;
                    end
                    else
                    begin
                        // 0x80 gives 128 literals
                        literals_left = 8'(9'h100 - {1'b0, it.data_byte});
                        parse_state   = PH_LITERAL;
                    end
                end
                PH_VALUE:
                begin
                    if (repeat_len != '0 && col_now < s)
                    begin
                        len = DIM_W'(repeat_len);
                        if (len > s - col_now)
                            len = s - col_now;
                        runs.push_back(make_run(col_now, it.data_byte, len, 1'b0));
                        col_now = col_now + len;
                    end
                    repeat_len = '0;
                    pkt_end    = 1'b1;
                end
                default:
                begin
                    // literal bytes past the stride are dropped
                    if (col_now < s)
                    begin
                        runs.push_back(make_run(col_now, it.data_byte, DIM_W'(1), 1'b0));
                        col_now = col_now + 1'b1;
                    end
                    if (literals_left <= 8'd1)
                    begin
                        literals_left = '0;
                        pkt_end       = 1'b1;
                    end
                    else
                        literals_left = literals_left - 1'b1;
                end
            endcase

            // row end: pad out to the stride, then next row or frame end
            if (pkt_end)
            begin
                if (col_now >= w)
                begin
                    if (col_now < s)
                        runs.push_back(make_run(col_now, PAD_PIXEL, s - col_now, 1'b1));
                    if ({1'b0, row_now} + 12'd1 >= h)
                    begin
                        frame_over = 1'b1;
                        frame      = 1'b1;
                    end
                    else
                        row_now = row_now + 1'b1;
                    col_now     = '0;
                    parse_state = PH_ROWCOUNT;
                end
                else
                    parse_state = PH_COUNT;
            end

            if (runs.size() > 0)
            begin
                runs[runs.size() - 1].last_result = 1'b1;
                if (frame)
                    runs[runs.size() - 1].frame_done = 1'b1;
            end
            foreach (runs[i])
                run_q.push_back(runs[i]);
        end
    endfunction

    // register write driver
    always @(posedge clk or negedge rst_n)
    begin : reg_writer
        reg_write_t wr;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_addr  <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    CFG_IMAGE_WIDTH:  reg_width  = cfg_data;
                    CFG_IMAGE_HEIGHT: reg_height = cfg_data;
                    CFG_ROW_STRIDE:   reg_stride = cfg_data;
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_write_q.size() != 0)
                begin
                    wr = reg_write_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_addr  <= wr.addr;
                    cfg_data  <= wr.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // byte driver: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(in_item);
            if (!in_valid || in_ready)
            begin
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(30, 80);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 6);
                    end
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    in_item  <= byte_q.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // run monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin : run_monitor
        brid_out_t want;
        logic      rdy;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (run_q.size() == 0)
                    report_mismatch($sformatf("unexpected run r%0d c%0d v%02h n%0d p%0b f%0b l%0b",
                        out_item.row_index, out_item.column_index, out_item.pixel_value,
                        out_item.run_length, out_item.is_padding, out_item.frame_done,
                        out_item.last_result));
                else
                begin
                    want = run_q.pop_front();
                    if (out_item.row_index    !== want.row_index    ||
                        out_item.column_index !== want.column_index ||
                        out_item.pixel_value  !== want.pixel_value  ||
                        out_item.run_length   !== want.run_length   ||
                        out_item.is_padding   !== want.is_padding   ||
                        out_item.frame_done   !== want.frame_done   ||
                        out_item.last_result  !== want.last_result)
                        report_mismatch($sformatf(
                            "got r%0d c%0d v%02h n%0d p%0b f%0b l%0b want r%0d c%0d v%02h n%0d p%0b f%0b l%0b",
                            out_item.row_index, out_item.column_index, out_item.pixel_value,
                            out_item.run_length, out_item.is_padding, out_item.frame_done,
                            out_item.last_result, want.row_index, want.column_index,
                            want.pixel_value, want.run_length, want.is_padding,
                            want.frame_done, want.last_result));
                end
            end

            // stall mode and mask are redrawn on a free-running cycle counter
            cycle_count++;
            if (cycle_count % 64 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_mask = 8'($urandom_range(0, 255));
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (holds_taken != hold_requests)
            begin
                holds_taken++;
                hold_left = LONG_HOLD - 1;
                rdy       = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = stall_mask[cycle_count % 8];
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            out_ready <= rdy;
        end
    end

    task automatic push_byte(input bit start, input int value);
        brid_in_t it;
        it.chunk_start = start;
        it.data_byte   = 8'(value);
        byte_q.push_back(it);
        bytes_made++;
    endtask

    // pixel values lean toward the extremes now and then
    function automatic int pick_value();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? 255 : 0;
        return $urandom_range(0, 255);
    endfunction

    // one well-formed row: packet count, then packets until the width
    task automatic gen_row(input bit start);
        int col;
        int remaining;
        int n;
        int kind;
        push_byte(start, $urandom_range(0, 255));
        col = 0;
        while (col < gen_w)
        begin
            remaining = gen_w - col;
            kind      = $urandom_range(0, 99);
            if (long_literal_due || kind >= 55 && remaining <= 64)
            begin
                if (long_literal_due)
                    n = 128;
                else if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(1, 20);
                else
                    n = $urandom_range(1, 6);
                long_literal_due = 1'b0;
                push_byte(1'b0, 256 - n);
                repeat (n)
                begin
                    push_byte(1'b0, pick_value());
                    if (col < gen_s)
                        col++;
                end
            end
            else if (kind < 10)
            begin
                // zero count: one byte consumed and dropped
                push_byte(1'b0, 0);
                push_byte(1'b0, $urandom_range(0, 255));
            end
            else
            begin
                if (remaining > 64)
                    n = $urandom_range(64, 127);
                else if ($urandom_range(0, 3) == 0)
                    n = $urandom_range(1, 127);
                else
                    n = $urandom_range(1, remaining + 2);
                push_byte(1'b0, n);
                push_byte(1'b0, pick_value());
                col += n;
                if (col > gen_s)
                    col = gen_s;
            end
        end
    endtask

    // frames of well-formed rows, some noise and some cut-off frames
    task automatic gen_phase(input int budget);
        int target;
        target = bytes_made + budget;
        while (bytes_made < target)
        begin
            if (rows_left == 0)
            begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 4))
                        push_byte($urandom_range(0, 1), $urandom_range(0, 255));
                if (gen_h <= 4)
                    rows_left = gen_h + (($urandom_range(0, 4) == 0) ? 1 : 0);
                else
                    rows_left = $urandom_range(1, 3);
                gen_row(1'b1);
                rows_left--;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                // broken frame: a row that stops early, next frame restarts
                push_byte(1'b0, $urandom_range(0, 255));
                push_byte(1'b0, $urandom_range(0, 255));
                push_byte(1'b0, $urandom_range(0, 255));
                rows_left = 0;
            end
            else
            begin
                gen_row(1'b0);
                rows_left--;
            end
        end
    endtask

    // block idle: no byte pending, every run seen, pipeline flushed
    task automatic wait_drained();
        @(negedge clk);
        while (byte_q.size() != 0 || in_valid || reg_write_q.size() != 0 ||
               cfg_valid || run_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_dims(input int w, input int h, input int s);
        reg_write_t wr;
        wr.addr = CFG_IMAGE_WIDTH;
        wr.data = DIM_W'(w);
        reg_write_q.push_back(wr);
        wr.addr = CFG_IMAGE_HEIGHT;
        wr.data = DIM_W'(h);
        reg_write_q.push_back(wr);
        wr.addr = CFG_ROW_STRIDE;
        wr.data = DIM_W'(s);
        reg_write_q.push_back(wr);
        gen_w = eff_dim(DIM_W'(w));
        gen_h = eff_dim(DIM_W'(h));
        gen_s = eff_dim(DIM_W'(s));
        if (gen_s < gen_w)
            gen_s = gen_w;
        wait_drained();
    endtask

    // main sequence
    initial
    begin : stimulus
        logic [8:0] seq [0:26];
        int w;
        int h;
        int s;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values
        gen_w = eff_dim(RST_IMAGE_WIDTH);
        gen_h = eff_dim(RST_IMAGE_HEIGHT);
        gen_s = eff_dim(RST_ROW_STRIDE);
        gen_phase(10);
        wait_drained();

        // directed: width 4, height 2, stride 6. Bit 8 is chunk_start.
        // Frame one: zero count, single literal, repeat clipped at the stride,
        // pad run with frame end, then ignored bytes. Frame two: row that
        // ends on a dropped literal in the last row.
        set_dims(4, 2, 6);
        seq = '{9'h1FF, 9'h000, 9'h0AA, 9'h0FF, 9'h000, 9'h07F, 9'h0FF, 9'h000,
                9'h002, 9'h055, 9'h0FE, 9'h001, 9'h002, 9'h012, 9'h034, 9'h100,
                9'h07F, 9'h080, 9'h000, 9'h003, 9'h001, 9'h0FC, 9'h07F, 9'h080,
                9'h081, 9'h082, 9'h000};
        foreach (seq[i])
            push_byte(seq[i][8], seq[i][7:0]);
        wait_drained();
        rows_left = 0;

        // random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: set_dims(0, 0, 0);
                1: set_dims(4095, 4095, 4095);
                2: set_dims(MAX_DIMENSION, 1, 1);
                3: set_dims(1, MAX_DIMENSION, MAX_DIMENSION);
                default:
                begin
                    w = $urandom_range(1, 40);
                    h = $urandom_range(1, 4);
                    s = w + $urandom_range(0, 12);
                    case ($urandom_range(0, 7))
                        0: s = $urandom_range(0, w - 1);
                        1: h = 0;
                        2:
                        begin
                            w = $urandom_range(100, 300);
                            s = w + $urandom_range(0, 40);
                        end
                        default: ;
                    endcase
                    set_dims(w, h, s);
                end
            endcase
            if (ph == 4)
                long_literal_due = 1'b1;
            if (ph == 5 || ph == 9)
                hold_requests++;
            gen_phase((ph == 1 || ph == 2) ? WIDE_BYTES : PHASE_BYTES);
            wait_drained();
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
